@@ src/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define TLFR_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, including those in reset.
`define TLFR_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/tlfr_pkg.sv @@
package tlfr_pkg;

   localparam int BYTE_W = 8;
   localparam int WORD_W = 32;
   localparam int KIND_W = 2;
   localparam int RSP_DATA_W = BYTE_W + 2 * WORD_W;

   localparam logic [WORD_W-1:0] MAX_SIZE_RESET = 32'd4096;

   typedef enum logic [3:0] {
      PH_TYPE    = 4'b0001,
      PH_SIZE    = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_DISCARD = 4'b1000
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA      = 2'd0,
      KIND_LAST_ACK  = 2'd1,
      KIND_EMPTY_ACK = 2'd2,
      KIND_NACK      = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [WORD_W-1:0]   frame_type;
      logic [WORD_W-1:0]   frame_size;
   } rsp_type;

endpackage

@@ src/tlfr_in_reg.sv @@
module tlfr_in_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tlfr_pkg::BYTE_W-1:0] req_tdata,
   input  logic                       take,
   output logic                       in_valid,
   output logic [tlfr_pkg::BYTE_W-1:0] in_byte
);
   import tlfr_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic              load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load ? 1'b1 : (take ? 1'b0 : valid_ff);
   assign byte_in    = load ? req_tdata : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

@@ src/tlfr_parser.sv @@
module tlfr_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tlfr_pkg::WORD_W-1:0] csr_wdata,
   input  logic                        in_valid,
   input  logic [tlfr_pkg::BYTE_W-1:0] in_byte,
   input  logic                        space,
   output logic                        consume,
   output logic                        res_valid,
   output tlfr_pkg::rsp_type           res
);
   import tlfr_pkg::*;

   phase_type         phase_ff;
   phase_type         phase_in;
   logic [1:0]        idx_ff;
   logic [1:0]        idx_in;
   logic [WORD_W-1:0] type_ff;
   logic [WORD_W-1:0] type_in;
   logic [WORD_W-1:0] size_ff;
   logic [WORD_W-1:0] size_in;
   logic [WORD_W-1:0] rem_ff;
   logic [WORD_W-1:0] rem_in;
   logic [WORD_W-1:0] max_ff;
   logic [WORD_W-1:0] max_in;
   logic [WORD_W-1:0] type_shift;
   logic [WORD_W-1:0] size_shift;
   logic              word_done;
   logic              last_byte;
   logic              emit;
   kind_type          kind;
   logic [BYTE_W-1:0] pbyte;

   assign consume    = in_valid && space;
   assign max_in     = csr_we ? csr_wdata : max_ff;
   assign type_shift = {type_ff[WORD_W-BYTE_W-1:0], in_byte};
   assign size_shift = {size_ff[WORD_W-BYTE_W-1:0], in_byte};
   assign word_done  = (idx_ff == 2'd3);
   assign last_byte  = (rem_ff[WORD_W-1:1] == '0);

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      type_in  = type_ff;
      size_in  = size_ff;
      rem_in   = rem_ff;
      emit     = 1'b0;
      kind     = KIND_DATA;
      pbyte    = '0;
      if (consume) begin
         case (phase_ff)
            PH_TYPE: begin
               type_in = type_shift;
               idx_in  = idx_ff + 2'd1;
               if (word_done) begin
                  phase_in = PH_SIZE;
               end
            end
            PH_SIZE: begin
               size_in = size_shift;
               idx_in  = idx_ff + 2'd1;
               if (word_done) begin
                  if (size_shift > max_ff) begin
                     rem_in   = size_shift;
                     phase_in = PH_DISCARD;
                  end else if (size_shift == '0) begin
                     phase_in = PH_TYPE;
                     emit     = 1'b1;
                     kind     = KIND_EMPTY_ACK;
                  end else begin
                     rem_in   = size_shift;
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               emit  = 1'b1;
               pbyte = in_byte;
               if (last_byte) begin
                  rem_in   = '0;
                  phase_in = PH_TYPE;
                  kind     = KIND_LAST_ACK;
               end else begin
                  rem_in = rem_ff - 32'd1;
               end
            end
            PH_DISCARD: begin
               if (last_byte) begin
                  rem_in   = '0;
                  phase_in = PH_TYPE;
                  emit     = 1'b1;
                  kind     = KIND_NACK;
               end else begin
                  rem_in = rem_ff - 32'd1;
               end
            end
            default: begin
               phase_in = PH_TYPE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         idx_ff   <= '0;
         type_ff  <= '0;
         size_ff  <= '0;
         rem_ff   <= '0;
         max_ff   <= MAX_SIZE_RESET;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         type_ff  <= type_in;
         size_ff  <= size_in;
         rem_ff   <= rem_in;
         max_ff   <= max_in;
      end
   end

   assign res_valid        = emit;
   assign res.kind         = kind;
   assign res.payload_byte = pbyte;
   assign res.frame_type   = type_in;
   assign res.frame_size   = size_in;

endmodule

@@ src/tlfr_out_reg.sv @@
module tlfr_out_reg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            res_valid,
   input  tlfr_pkg::rsp_type               res,
   output logic                            space,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tlfr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [tlfr_pkg::KIND_W-1:0]     rsp_tuser
);
   import tlfr_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;

   assign space    = !valid_ff || rsp_tready;
   assign valid_in = res_valid ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   assign data_in  = res_valid ? res : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.frame_size, data_ff.frame_type, data_ff.payload_byte};
   assign rsp_tuser  = data_ff.kind;

endmodule

@@ src/type_length_frame_receiver.sv @@
// Channel    Direction  Transaction
// req_*      in         one received byte in tdata[7:0]
// rsp_*      out        payload byte, frame type and frame size in tdata, kind in tuser
// csr_*      in         write of the maximum payload size, no read-back
//
// Each byte is registered in the input register and passes through the combinational parser into the result register.
// A byte is accepted every cycle while the result register is empty or being drained.
// Synchronous reset returns to the type header and restores a maximum of 4096 bytes.
// A stall on rsp_tready backs up through the input register to req_tready.
module type_length_frame_receiver (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rx_byte [7:0]
   input  logic [tlfr_pkg::BYTE_W-1:0]     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // payload_byte [7:0], frame_type [39:8], frame_size [71:40]
   output logic [tlfr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind [1:0]
   output logic [tlfr_pkg::KIND_W-1:0]     rsp_tuser,
   input  logic                            csr_we,
   input  logic [tlfr_pkg::WORD_W-1:0]     csr_wdata
);
   import tlfr_pkg::*;

   logic              in_valid;
   logic [BYTE_W-1:0] in_byte;
   logic              consume;
   logic              space;
   logic              res_valid;
   rsp_type           res;

   tlfr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (consume),
      .in_valid   (in_valid),
      .in_byte    (in_byte)
   );

   tlfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (in_valid),
      .in_byte   (in_byte),
      .space     (space),
      .consume   (consume),
      .res_valid (res_valid),
      .res       (res)
   );

   tlfr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ src/tlfr_checker.sv @@
`include "assert_macros.svh"

module tlfr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tlfr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [tlfr_pkg::KIND_W-1:0]     rsp_tuser
);
   import tlfr_pkg::*;

   `TLFR_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid, "result valid after reset")

   `TLFR_ASSERT(a_rsp_hold,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "stalled result changed")

   `TLFR_ASSERT(a_ack_nack_no_byte,
      rsp_tvalid && (rsp_tuser == KIND_EMPTY_ACK || rsp_tuser == KIND_NACK)
         |-> rsp_tdata[BYTE_W-1:0] == '0,
      "payload byte set on an acknowledge")

   `TLFR_ASSERT(a_empty_size,
      rsp_tvalid && rsp_tuser == KIND_EMPTY_ACK
         |-> rsp_tdata[RSP_DATA_W-1:BYTE_W+WORD_W] == '0,
      "empty acknowledge with nonzero size")

   `TLFR_ASSERT(a_nack_size,
      rsp_tvalid && rsp_tuser == KIND_NACK
         |-> rsp_tdata[RSP_DATA_W-1:BYTE_W+WORD_W] != '0,
      "refusal of a frame with zero size")

endmodule

bind type_length_frame_receiver tlfr_checker u_tlfr_checker (.*);
